>>> rtl/core/owtp_pkg.sv
// shared types and constants for the one-wire temperature poller
package owtp_pkg;

  localparam int TICK_W    = 10;
  localparam int TEMP_W    = 16;
  localparam int BITPOS_W  = 6;
  localparam int CFG_IDX_W = 3;

  localparam logic [TICK_W-1:0]   TICK_MAX  = 10'd1023;
  localparam logic [BITPOS_W-1:0] READ_BITS = 6'd31;
  localparam logic [BITPOS_W-1:0] CMD_BITS  = 6'd8;
  localparam logic [BITPOS_W-1:0] TEMP_BITS = 6'd16;

  localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
  localparam logic [7:0] CMD_CONVERT  = 8'h44;
  localparam logic [7:0] CMD_READ_PAD = 8'hBE;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRES_START = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRES_END   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRES_WAIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT       = 3'd4;

  localparam logic [TICK_W-1:0] RST_RESET_LOW  = 10'd480;
  localparam logic [TICK_W-1:0] RST_PRES_START = 10'd80;
  localparam logic [TICK_W-1:0] RST_PRES_END   = 10'd240;
  localparam logic [TICK_W-1:0] RST_PRES_WAIT  = 10'd480;
  localparam logic [TICK_W-1:0] RST_SLOT       = 10'd60;

  typedef struct packed {
    logic [TICK_W-1:0] reset_low;
    logic [TICK_W-1:0] pres_start;
    logic [TICK_W-1:0] pres_end;
    logic [TICK_W-1:0] pres_wait;
    logic [TICK_W-1:0] slot;
  } cfg_t;

  typedef struct packed {
    logic              drive_low;
    logic [TEMP_W-1:0] temperature;
    logic              new_reading;
  } result_t;

endpackage

>>> rtl/core/owtp_if.sv
// request channel interfaces: tick input, result output, register write
interface owtp_in_if;
  logic valid;
  logic ready;
  logic bus_level;
  modport source (output valid, output bus_level, input ready);
  modport sink (input valid, input bus_level, output ready);
endinterface

interface owtp_out_if import owtp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              drive_low;
  logic [TEMP_W-1:0] temperature_raw;
  logic              new_reading;
  modport source (output valid, output drive_low, output temperature_raw,
                  output new_reading, input ready);
  modport sink (input valid, input drive_low, input temperature_raw,
                input new_reading, output ready);
endinterface

interface owtp_cfg_if import owtp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [TICK_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/owtp_cfg_regs.sv
// timing configuration registers
module owtp_cfg_regs import owtp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [TICK_W-1:0]    wr_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        CFG_RESET_LOW:  cfg_nxt.reset_low  = wr_data;
        CFG_PRES_START: cfg_nxt.pres_start = wr_data;
        CFG_PRES_END:   cfg_nxt.pres_end   = wr_data;
        CFG_PRES_WAIT:  cfg_nxt.pres_wait  = wr_data;
        CFG_SLOT:       cfg_nxt.slot       = wr_data;
        default:        cfg_nxt = cfg_r;  // unmapped index
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low  <= RST_RESET_LOW;
      cfg_r.pres_start <= RST_PRES_START;
      cfg_r.pres_end   <= RST_PRES_END;
      cfg_r.pres_wait  <= RST_PRES_WAIT;
      cfg_r.slot       <= RST_SLOT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/core/owtp_engine.sv
// bus sequencer: one tick step of reset, command write and read slots
module owtp_engine import owtp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step,
  input  logic    level,
  input  cfg_t    cfg,
  output result_t res
);

  typedef enum logic [3:0] {
    PH_RST_START, PH_RST_LOW, PH_PRESENCE, PH_LOAD_SKIP, PH_LOAD_CONVERT,
    PH_LOAD_READ, PH_WSLOT_START, PH_WSLOT_BIT, PH_WSLOT_WAIT, PH_RSLOT_START,
    PH_RSLOT_RELEASE, PH_RSLOT_SAMPLE, PH_RSLOT_WAIT
  } phase_t;

  typedef enum logic [1:0] {
    RND_SKIP_CONVERT, RND_CONVERT, RND_SKIP_READ, RND_READ
  } round_t;

  phase_t              phase_r, phase_nxt;
  round_t              round_r, round_nxt;
  logic [TICK_W-1:0]   tick_r, tick_nxt, tick_inc;
  logic [BITPOS_W-1:0] bitpos_r, bitpos_nxt, bitpos_inc;
  logic [7:0]          cmd_r, cmd_nxt;
  logic [TEMP_W-1:0]   rx_r, rx_nxt;
  logic                pres_r, pres_nxt;
  logic                drive_r, drive_nxt;
  logic [TEMP_W-1:0]   temp_r, temp_nxt;
  logic                strobe;

  assign tick_inc   = (tick_r < TICK_MAX) ? tick_r + 10'd1 : tick_r;
  assign bitpos_inc = bitpos_r + 6'd1;

  always_comb begin
    phase_nxt  = phase_r;
    round_nxt  = round_r;
    tick_nxt   = tick_inc;
    bitpos_nxt = bitpos_r;
    cmd_nxt    = cmd_r;
    rx_nxt     = rx_r;
    pres_nxt   = pres_r;
    drive_nxt  = drive_r;
    temp_nxt   = temp_r;
    strobe     = 1'b0;
    unique case (phase_r)
      PH_RST_LOW: begin
        if (tick_inc >= cfg.reset_low) begin
          drive_nxt = 1'b0;
          pres_nxt  = level;
          tick_nxt  = '0;
          phase_nxt = PH_PRESENCE;
        end
      end
      PH_PRESENCE: begin
        // window end at the saturated count closes the window
        if (tick_inc <= cfg.pres_end && tick_inc < TICK_MAX) begin
          if (tick_inc >= cfg.pres_start && pres_r) begin
            pres_nxt = level;
          end
        end else if (tick_inc >= cfg.pres_wait) begin
          phase_nxt = pres_r ? PH_RST_START : PH_LOAD_SKIP;
        end
      end
      PH_LOAD_SKIP: begin
        cmd_nxt    = CMD_SKIP_ROM;
        bitpos_nxt = '0;
        phase_nxt  = PH_WSLOT_START;
      end
      PH_LOAD_CONVERT: begin
        cmd_nxt    = CMD_CONVERT;
        bitpos_nxt = '0;
        round_nxt  = RND_CONVERT;
        phase_nxt  = PH_WSLOT_START;
      end
      PH_LOAD_READ: begin
        cmd_nxt    = CMD_READ_PAD;
        bitpos_nxt = '0;
        round_nxt  = RND_READ;
        phase_nxt  = PH_WSLOT_START;
      end
      PH_WSLOT_START: begin
        drive_nxt = 1'b1;
        tick_nxt  = '0;
        phase_nxt = PH_WSLOT_BIT;
      end
      PH_RSLOT_START: begin
        drive_nxt = 1'b1;
        tick_nxt  = '0;
        phase_nxt = PH_RSLOT_RELEASE;
      end
      PH_WSLOT_BIT: begin
        if (cmd_r[bitpos_r[2:0]]) begin
          drive_nxt = 1'b0;
        end
        phase_nxt = PH_WSLOT_WAIT;
      end
      PH_WSLOT_WAIT: begin
        if (tick_inc >= cfg.slot) begin
          drive_nxt  = 1'b0;
          bitpos_nxt = bitpos_inc;
          if (bitpos_inc < CMD_BITS) begin
            phase_nxt = PH_WSLOT_START;
          end else begin
            unique case (round_r)
              RND_SKIP_CONVERT: phase_nxt = PH_LOAD_CONVERT;
              RND_CONVERT: begin
                round_nxt = RND_SKIP_READ;
                phase_nxt = PH_RST_START;
              end
              RND_SKIP_READ: phase_nxt = PH_LOAD_READ;
              default: begin
                bitpos_nxt = '0;
                rx_nxt     = '0;
                phase_nxt  = PH_RSLOT_START;
              end
            endcase
          end
        end
      end
      PH_RSLOT_RELEASE: begin
        drive_nxt = 1'b0;
        phase_nxt = PH_RSLOT_SAMPLE;
      end
      PH_RSLOT_SAMPLE: begin
        pres_nxt = level;
        if (bitpos_r < TEMP_BITS) begin
          rx_nxt[bitpos_r[3:0]] = rx_r[bitpos_r[3:0]] | level;
        end
        phase_nxt = PH_RSLOT_WAIT;
      end
      PH_RSLOT_WAIT: begin
        if (tick_inc >= cfg.slot) begin
          bitpos_nxt = bitpos_inc;
          if (bitpos_inc >= READ_BITS) begin
            temp_nxt  = rx_r;
            strobe    = 1'b1;
            round_nxt = RND_SKIP_CONVERT;
            phase_nxt = PH_RST_START;
          end else begin
            phase_nxt = PH_RSLOT_START;
          end
        end
      end
      default: begin
        // reset pulse start, also taken by unused codes
        drive_nxt = 1'b1;
        tick_nxt  = '0;
        phase_nxt = PH_RST_LOW;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_RST_START;
      round_r <= RND_SKIP_CONVERT;
      tick_r  <= '0;
      drive_r <= 1'b0;
      temp_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      round_r <= round_nxt;
      tick_r  <= tick_nxt;
      drive_r <= drive_nxt;
      temp_r  <= temp_nxt;
    end
  end

  // written before they are read, so no reset
  always_ff @(posedge clk) begin
    if (step) begin
      bitpos_r <= bitpos_nxt;
      cmd_r    <= cmd_nxt;
      rx_r     <= rx_nxt;
      pres_r   <= pres_nxt;
    end
  end

  assign res.drive_low   = drive_nxt;
  assign res.temperature = temp_nxt;
  assign res.new_reading = strobe;

endmodule

>>> rtl/core/one_wire_temperature_poller.sv
// top level of the one-wire temperature poller
// One request on the input channel is one microsecond tick carrying the
// sampled bus level; every request produces exactly one result request with
// the open-drain drive state (1 pulls the line low), the latest 16-bit raw
// temperature word and a strobe that marks the tick on which a new word was
// captured. The block takes one tick per clock cycle: a tick sits in an input
// register, the sequencer step between that register and the result register
// is combinational logic, and a new tick can enter every cycle as long as
// results are taken. While a result waits in the result register, the input
// register holds one more tick and then the input channel stalls until the
// result is taken.
// Timing registers are written through the configuration channel,
// which is always ready; indexes outside the five registers are ignored.
// There is no clearing pass after reset.
module one_wire_temperature_poller import owtp_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  owtp_in_if.sink       in_ch,
  owtp_out_if.source    out_ch,
  owtp_cfg_if.sink      cfg_ch
);

  cfg_t    cfg;
  result_t res;

  logic              s1_valid_r;
  logic              s1_level_r;
  logic              out_valid_r;
  logic              out_drive_r;
  logic [TEMP_W-1:0] out_temp_r;
  logic              out_strobe_r;
  logic              out_free;
  logic              step;
  logic              in_take;

  // register writes land at once
  assign cfg_ch.ready = 1'b1;

  owtp_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  // result register is free when empty or being drained
  assign out_free    = !out_valid_r || out_ch.ready;
  assign step        = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || step;
  assign in_take     = in_ch.valid && in_ch.ready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_level_r <= in_ch.bus_level;
    end
  end

  owtp_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .level (s1_level_r),
    .cfg   (cfg),
    .res   (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_drive_r  <= res.drive_low;
      out_temp_r   <= res.temperature;
      out_strobe_r <= res.new_reading;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.drive_low       = out_drive_r;
  assign out_ch.temperature_raw = out_temp_r;
  assign out_ch.new_reading     = out_strobe_r;

endmodule

>>> rtl/core/owtp_checker.sv
// port-level checks for the one-wire temperature poller, bound to the top
module owtp_checker import owtp_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic              drive_low,
  input logic [TEMP_W-1:0] temperature_raw,
  input logic              new_reading
);

  // a capture ends a read slot, where the line is already released
  a_strobe_released: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && new_reading) |-> !drive_low)
    else $error("new reading while driving the bus low");

  // two captures are a whole poll cycle apart
  a_strobe_spaced: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && new_reading) |=> !(out_valid && new_reading))
    else $error("new reading on consecutive results");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(drive_low) &&
      $stable(temperature_raw) && $stable(new_reading)))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind one_wire_temperature_poller owtp_checker u_owtp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .drive_low       (out_ch.drive_low),
  .temperature_raw (out_ch.temperature_raw),
  .new_reading     (out_ch.new_reading)
);
